// ----- hw/rtl/ntc_pkg.sv -----
package ntc_pkg;

  typedef enum logic [2:0] {
    TY_I32 = 3'd0,
    TY_I64 = 3'd1,
    TY_U32 = 3'd2,
    TY_U64 = 3'd3,
    TY_F32 = 3'd4,
    TY_F64 = 3'd5
  } ntype_t;

  localparam logic [1:0] REG_SRC_TYPE = 2'd0;
  localparam logic [1:0] REG_TGT_TYPE = 2'd1;
  localparam logic [1:0] REG_SRC_BE   = 2'd2;
  localparam logic [1:0] REG_TGT_BE   = 2'd3;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FIN  = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } ncls_t;

  typedef struct packed {
    logic [63:0] source_value;
    logic        final_element;
  } in_word_t;

  typedef struct packed {
    logic [63:0] converted_value;
    logic        final_out;
  } out_word_t;

  // classified element handed from front to back
  typedef struct packed {
    logic        pass;     // same source and target type
    logic        zero_out; // bad type code
    logic        is_int;
    ncls_t       cls;
    logic        neg;
    logic [63:0] mant;     // also raw bits / integer value
    logic [12:0] exp;      // signed
    logic [51:0] payload;  // top-aligned nan payload
    logic [2:0]  tt;
    logic        tbe;
    logic        fin;
  } cls_word_t;

  // between the two convert stages: aligned value before rounding / saturation
  typedef struct packed {
    logic               done;     // val already final, only width and order left
    logic               to_flt;
    logic               neg;
    logic               sg;
    logic               ovf;
    logic               rnd;
    logic [63:0]        val;
    logic signed [13:0] q;
    logic [2:0]         tt;
    logic               tbe;
    logic               zero_out;
    logic               fin;
  } mid_word_t;

  function automatic logic is_wide(input logic [2:0] t);
    return (t == TY_I64) || (t == TY_U64) || (t == TY_F64);
  endfunction

  function automatic logic [63:0] bswap(input logic [63:0] v, input logic w);
    logic [63:0] r;
    r = '0;
    if (w) begin
      for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
    end else begin
      for (int i = 0; i < 4; i++) r[8*i +: 8] = v[8*(3-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ntc_front.sv -----
module ntc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [2:0]          cfg_data,
  input  ntc_pkg::in_word_t   word_i,
  output ntc_pkg::cls_word_t  cls_o
);
  import ntc_pkg::*;

  logic [2:0] st_r, tt_r;
  logic       sbe_r, tbe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0; tt_r <= '0; sbe_r <= 1'b0; tbe_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_TYPE: st_r <= cfg_data;
        REG_TGT_TYPE: tt_r <= cfg_data;
        REG_SRC_BE:   sbe_r <= cfg_data[0];
        REG_TGT_BE:   tbe_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [63:0] raw;
  logic        w;

  always_comb begin
    w = is_wide(st_r);
    raw = w ? word_i.source_value : {32'd0, word_i.source_value[31:0]};
    if (sbe_r) raw = bswap(raw, w);
    cls_o = '0;
    cls_o.tt = tt_r;
    cls_o.tbe = tbe_r;
    cls_o.fin = word_i.final_element;
    cls_o.zero_out = (st_r > TY_F64) || (tt_r > TY_F64);
    cls_o.pass = (st_r == tt_r);
    cls_o.mant = raw;
    case (st_r)
      TY_I32, TY_I64, TY_U32, TY_U64: begin
        if (st_r == TY_I32) raw = {{32{raw[31]}}, raw[31:0]};
        cls_o.is_int = 1'b1;
        cls_o.neg = (st_r == TY_I32 || st_r == TY_I64) && raw[63];
        cls_o.mant = cls_o.neg ? (64'd0 - raw) : raw;
        cls_o.cls = (cls_o.mant != 0) ? CLS_FIN : CLS_ZERO;
        // integer targets use the extended value directly
        if (tt_r <= TY_U64) cls_o.mant = raw;
        cls_o.exp = '0;
      end
      TY_F32: begin
        cls_o.neg = raw[31];
        cls_o.mant = {41'd0, raw[22:0]};
        if (raw[30:23] == 8'hff) begin
          cls_o.cls = (raw[22:0] != 0) ? CLS_NAN : CLS_INF;
          cls_o.payload = {raw[22:0], 29'd0};
        end else if (raw[30:23] == 8'd0) begin
          cls_o.cls = (raw[22:0] != 0) ? CLS_FIN : CLS_ZERO;
          cls_o.exp = -13'sd149;
        end else begin
          cls_o.cls = CLS_FIN;
          cls_o.mant[23] = 1'b1;
          cls_o.exp = {5'd0, raw[30:23]} - 13'd150;
        end
      end
      TY_F64: begin
        cls_o.neg = raw[63];
        cls_o.mant = {12'd0, raw[51:0]};
        if (raw[62:52] == 11'h7ff) begin
          cls_o.cls = (raw[51:0] != 0) ? CLS_NAN : CLS_INF;
          cls_o.payload = raw[51:0];
        end else if (raw[62:52] == 11'd0) begin
          cls_o.cls = (raw[51:0] != 0) ? CLS_FIN : CLS_ZERO;
          cls_o.exp = -13'sd1074;
        end else begin
          cls_o.cls = CLS_FIN;
          cls_o.mant[52] = 1'b1;
          cls_o.exp = {2'd0, raw[62:52]} - 13'd1075;
        end
      end
      default: ;
    endcase
    // same type: the raw bits go through untouched
    if (cls_o.pass) cls_o.mant = raw;
  end

endmodule

// ----- hw/rtl/ntc_fifo.sv -----
module ntc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ntc_pkg::cls_word_t push_data,
  output logic               full,
  input  logic               pop,
  output ntc_pkg::cls_word_t pop_data,
  output logic               empty
);
  import ntc_pkg::*;

  cls_word_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/ntc_back.sv -----
module ntc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_take,
  input  ntc_pkg::cls_word_t cls_i,
  output logic               out_valid,
  input  logic               out_stall,
  output ntc_pkg::out_word_t word_o
);
  import ntc_pkg::*;

  // first half: settle specials and pass-through, align the mantissa, flag overflow, decide the rounding bit
  function automatic mid_word_t stage_a(input cls_word_t n);
    mid_word_t          o;
    logic               dbl, sg;
    logic [5:0]         fb;
    logic signed [13:0] bias, maxe, emin, etop, shf;
    logic [63:0]        sw, infw, rem, hlf;
    logic [6:0]         m, sh;
    o = '0;
    o.tt = n.tt;
    o.tbe = n.tbe;
    o.zero_out = n.zero_out;
    o.fin = n.fin;
    o.neg = n.neg;
    dbl = (n.tt != TY_F32);
    sg = (n.tt == TY_I32) || (n.tt == TY_I64);
    o.sg = sg;
    fb = dbl ? 6'd52 : 6'd23;
    bias = dbl ? 14'sd1023 : 14'sd127;
    maxe = dbl ? 14'sd2047 : 14'sd255;
    emin = 14'sd1 - bias;
    sw = n.neg ? (64'd1 << (fb + (dbl ? 6'd11 : 6'd8))) : '0;
    infw = sw | (64'(maxe) << fb);
    m = '0;
    sh = '0;
    etop = '0;
    shf = '0;
    rem = '0;
    hlf = '0;
    if (n.zero_out) begin
      o.done = 1'b1;
    end else if (n.pass) begin
      o.done = 1'b1;
      o.val = n.mant;
    end else if (n.tt <= TY_U64) begin
      if (n.is_int) begin
        o.done = 1'b1;
        o.val = n.mant;
      end else if (n.cls == CLS_NAN || n.cls == CLS_ZERO) begin
        o.done = 1'b1;
      end else if (n.cls == CLS_INF) begin
        o.ovf = 1'b1;
      end else if (!n.exp[12]) begin
        if (n.exp >= 13'd64) o.ovf = 1'b1;
        else begin
          sh = n.exp[6:0];
          if (sh != 0 && ((n.mant >> (7'd64 - sh)) != 0)) o.ovf = 1'b1;
          else o.val = n.mant << sh;
        end
      end else if ($signed(n.exp) > -13'sd64) begin
        sh = 7'(-n.exp);
        o.val = n.mant >> sh;
      end
    end else begin
      o.to_flt = 1'b1;
      if (n.cls == CLS_ZERO) begin
        o.done = 1'b1;
        o.val = sw;
      end else if (n.cls == CLS_INF) begin
        o.done = 1'b1;
        o.val = infw;
      end else if (n.cls == CLS_NAN) begin
        o.done = 1'b1;
        o.val = infw | (64'd1 << (fb - 6'd1)) |
                (dbl ? {12'd0, n.payload} : {41'd0, n.payload[51:29]});
      end else begin
        for (int i = 0; i < 64; i++) if (n.mant[i]) m = 7'(i);
        etop = 14'(m) + 14'($signed(n.exp));
        o.q = ((etop > emin) ? etop : emin) - 14'(fb);
        shf = o.q - 14'($signed(n.exp));
        if (shf <= 0) o.val = n.mant << 7'(-shf);
        else if (shf > 14'sd64) o.val = '0;
        else if (shf == 14'sd64)
          o.val = (n.mant > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
        else begin
          rem = n.mant & ((64'd1 << shf[5:0]) - 64'd1);
          hlf = 64'd1 << (shf[5:0] - 6'd1);
          o.val = n.mant >> shf[5:0];
          o.rnd = (rem > hlf) || (rem == hlf && o.val[0]);
        end
      end
    end
    return o;
  endfunction

  // second half: round and pack, or saturate, then width and byte order
  function automatic logic [63:0] stage_b(input mid_word_t p);
    logic               tw, dbl;
    logic [5:0]         fb;
    logic signed [13:0] bias, maxe, q, biased;
    logic [63:0]        wmask, half, lim, mag, sw, infw, r, fmask, res;
    tw = is_wide(p.tt);
    dbl = (p.tt != TY_F32);
    fb = dbl ? 6'd52 : 6'd23;
    bias = dbl ? 14'sd1023 : 14'sd127;
    maxe = dbl ? 14'sd2047 : 14'sd255;
    fmask = (64'd1 << fb) - 64'd1;
    sw = p.neg ? (64'd1 << (fb + (dbl ? 6'd11 : 6'd8))) : '0;
    infw = sw | (64'(maxe) << fb);
    wmask = tw ? '1 : 64'h0000_0000_ffff_ffff;
    half = tw ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    lim = p.sg ? half - 64'd1 : wmask;
    q = p.q;
    biased = '0;
    r = p.val + {63'd0, p.rnd};
    mag = p.val;
    if (p.done) res = p.val;
    else if (p.to_flt) begin
      if ((r >> (fb + 6'd1)) != 0) begin
        r = r >> 1; q = q + 14'sd1;
      end
      if ((r >> fb) != 0) begin
        biased = q + 14'(fb) + bias;
        res = (biased >= maxe) ? infw : (sw | (64'(biased) << fb) | (r & fmask));
      end else res = sw | r;
    end else if (p.neg) begin
      if (!p.sg) res = '0;
      else begin
        if (p.ovf || mag > half) mag = half;
        res = (64'd0 - mag) & wmask;
      end
    end else begin
      if (p.ovf || mag > lim) mag = lim;
      res = mag & wmask;
    end
    if (!tw) res = {32'd0, res[31:0]};
    if (p.tbe && !p.zero_out) res = bswap(res, tw);
    return res;
  endfunction

  mid_word_t mid_r;
  logic      mid_v_r, ov_r;
  out_word_t od_r;
  logic      adv_out, adv_mid;

  assign adv_out = !ov_r || !out_stall;
  assign adv_mid = !mid_v_r || adv_out;
  assign in_take = in_valid && adv_mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (adv_mid) mid_v_r <= in_valid;
      if (adv_out) ov_r <= mid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) mid_r <= stage_a(cls_i);
    if (adv_out && mid_v_r) begin
      od_r.converted_value <= stage_b(mid_r);
      od_r.final_out <= mid_r.fin;
    end
  end

  assign out_valid = ov_r;
  assign word_o = od_r;

endmodule

// ----- hw/rtl/numeric_type_converter.sv -----
// Takes one word per cycle in steady state while out_stall is low; a result
// leaves the output register after the queue write and then the two convert
// stages, aligning and then rounding or saturating. The front
// classifies the word combinationally into a two-entry queue; behind it the
// convert pipeline holds two more words. When out_stall is held, up to four
// words are taken before in_stall rises, which happens only with the queue
// full. Configuration writes must be done while no words are in flight.
module numeric_type_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ntc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ntc_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_data
);
  import ntc_pkg::*;

  cls_word_t cls_w, q_w;
  logic      full, empty, push, pop;

  ntc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .word_i(in_data), .cls_o(cls_w)
  );

  assign in_stall = full;
  assign push = in_valid && !full;

  ntc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(cls_w), .full(full),
    .pop(pop), .pop_data(q_w), .empty(empty)
  );

  ntc_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(!empty), .in_take(pop), .cls_i(q_w),
    .out_valid(out_valid), .out_stall(out_stall), .word_o(out_data)
  );

endmodule

// ----- tb/numeric_type_converter_test.sv -----
`timescale 1ns / 100ps

module numeric_type_converter_test;
  import ntc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  numeric_type_converter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // converter settings mirrored in the testbench
  logic [2:0] src_ty, tgt_ty;
  logic src_be, tgt_be;

  out_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  typedef struct {
    ncls_t cls;
    logic neg;
    logic [63:0] mant;
    int ex;
    logic [63:0] payload;
    logic [63:0] ival;
    logic is_int;
  } num_fields_t;

  function automatic logic is_eight(input logic [2:0] t);
    return t == TY_I64 || t == TY_U64 || t == TY_F64;
  endfunction

  function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input logic eight);
    logic [63:0] r;
    int n;
    r = '0;
    n = eight ? 8 : 4;
    for (int i = 0; i < n; i++) r = (r << 8) | ((v >> (8 * i)) & 64'hff);
    return r;
  endfunction

  function automatic num_fields_t unpack_num(input logic [63:0] v, input logic [2:0] t);
    num_fields_t n;
    logic [63:0] ex, fr;
    n.cls = CLS_ZERO; n.neg = 0; n.mant = 0; n.ex = 0; n.payload = 0; n.ival = 0;
    n.is_int = 0;
    if (t <= TY_U64) begin
      n.is_int = 1;
      if (t == TY_I32) v = {{32{v[31]}}, v[31:0]};
      else if (t == TY_U32) v = {32'd0, v[31:0]};
      n.ival = v;
      n.neg = (t <= TY_I64) && v[63];
      n.mant = n.neg ? -v : v;
      n.cls = n.mant != 0 ? CLS_FIN : CLS_ZERO;
    end else if (t == TY_F32) begin
      ex = (v >> 23) & 64'hff; fr = v & 64'h7fffff;
      n.neg = v[31];
      if (ex == 64'hff) begin
        n.cls = fr != 0 ? CLS_NAN : CLS_INF; n.payload = fr << 41;
      end else if (ex == 0) begin
        n.cls = fr != 0 ? CLS_FIN : CLS_ZERO; n.mant = fr; n.ex = -149;
      end else begin
        n.cls = CLS_FIN; n.mant = fr | 64'h800000; n.ex = int'(ex) - 150;
      end
    end else begin
      ex = (v >> 52) & 64'h7ff; fr = v & 64'hfffffffffffff;
      n.neg = v[63];
      if (ex == 64'h7ff) begin
        n.cls = fr != 0 ? CLS_NAN : CLS_INF; n.payload = fr << 12;
      end else if (ex == 0) begin
        n.cls = fr != 0 ? CLS_FIN : CLS_ZERO; n.mant = fr; n.ex = -1074;
      end else begin
        n.cls = CLS_FIN; n.mant = fr | 64'h10000000000000; n.ex = int'(ex) - 1075;
      end
    end
    return n;
  endfunction

  function automatic logic [63:0] round_to_float(input num_fields_t n, input int fb,
                                                  input int eb);
    int bias, maxe, emin, m, e_top, q, sh, biased;
    logic [63:0] fmask, sw, infw, r, rem, half;
    bias = (1 << (eb - 1)) - 1;
    maxe = (1 << eb) - 1;
    emin = 1 - bias;
    fmask = (64'd1 << fb) - 1;
    sw = n.neg ? (64'd1 << (fb + eb)) : 64'd0;
    infw = sw | (64'(maxe) << fb);
    if (n.cls == CLS_ZERO) return sw;
    if (n.cls == CLS_INF) return infw;
    if (n.cls == CLS_NAN) return infw | (64'd1 << (fb - 1)) | ((n.payload >> (64 - fb)) & fmask);
    m = 63;
    while (m > 0 && !n.mant[m]) m--;
    e_top = m + n.ex;
    q = (e_top > emin ? e_top : emin) - fb;
    sh = q - n.ex;
    if (sh <= 0) r = n.mant << (-sh);
    else if (sh > 64) r = 0;
    else if (sh == 64) r = (n.mant > 64'h8000000000000000) ? 1 : 0;
    else begin
      rem = n.mant & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      r = n.mant >> sh;
      if (rem > half || (rem == half && r[0])) r++;
    end
    if ((r >> (fb + 1)) != 0) begin
      r >>= 1; q++;
    end
    if ((r >> fb) != 0) begin
      biased = q + fb + bias;
      if (biased >= maxe) return infw;
      return sw | (64'(biased) << fb) | (r & fmask);
    end
    return sw | r;
  endfunction

  function automatic logic [63:0] truncate_to_int(input num_fields_t n, input int bits,
                                                   input logic sgn);
    logic [63:0] wmask, half, lim, mag;
    logic ovf;
    wmask = bits == 64 ? '1 : 64'hffffffff;
    half = 64'd1 << (bits - 1);
    lim = sgn ? half - 1 : wmask;
    mag = 0; ovf = 0;
    if (n.cls == CLS_NAN || n.cls == CLS_ZERO) return 0;
    if (n.cls == CLS_INF) ovf = 1;
    else if (n.ex >= 0) begin
      if (n.ex >= 64) ovf = 1;
      else if (n.ex > 0 && (n.mant >> (64 - n.ex)) != 0) ovf = 1;
      else mag = n.mant << n.ex;
    end else mag = (-n.ex >= 64) ? 64'd0 : (n.mant >> (-n.ex));
    if (n.neg) begin
      if (!sgn) return 0;
      if (ovf || mag > half) mag = half;
      return (-mag) & wmask;
    end
    if (ovf || mag > lim) mag = lim;
    return mag & wmask;
  endfunction

  function automatic out_word_t convert_word(input in_word_t w);
    out_word_t o;
    logic [63:0] raw, res;
    num_fields_t n;
    raw = w.source_value;
    res = 0;
    if (src_ty <= TY_F64 && tgt_ty <= TY_F64) begin
      if (!is_eight(src_ty)) raw &= 64'hffffffff;
      if (src_be) raw = reverse_bytes(raw, is_eight(src_ty));
      if (src_ty == tgt_ty) res = raw;
      else begin
        n = unpack_num(raw, src_ty);
        case (tgt_ty)
          TY_I32: res = n.is_int ? n.ival : truncate_to_int(n, 32, 1);
          TY_I64: res = n.is_int ? n.ival : truncate_to_int(n, 64, 1);
          TY_U32: res = n.is_int ? n.ival : truncate_to_int(n, 32, 0);
          TY_U64: res = n.is_int ? n.ival : truncate_to_int(n, 64, 0);
          TY_F32: res = round_to_float(n, 23, 8);
          default: res = round_to_float(n, 52, 11);
        endcase
      end
      if (!is_eight(tgt_ty)) res &= 64'hffffffff;
      if (tgt_be) res = reverse_bytes(res, is_eight(tgt_ty));
    end
    o.converted_value = res;
    o.final_out = w.final_element;
    return o;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    out_word_t e;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors = errors + 1;
      end else begin
        e = expected_words.pop_front();
        if (e.converted_value !== out_data.converted_value) begin
          $display("%0t: value exp %h got %h", $time, e.converted_value,
                   out_data.converted_value);
          errors = errors + 1;
        end
        if (e.final_out !== out_data.final_out) begin
          $display("%0t: final exp %b got %b", $time, e.final_out, out_data.final_out);
          errors = errors + 1;
        end
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  task automatic send_word(input logic [63:0] v, input logic fin);
    in_word_t w;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    w.source_value = v;
    w.final_element = fin;
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(convert_word(w));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_TYPE: src_ty = val;
      REG_TGT_TYPE: tgt_ty = val;
      REG_SRC_BE: src_be = val[0];
      default: tgt_be = val[0];
    endcase
  endtask

  task automatic set_mode(input logic [2:0] s, input logic [2:0] t, input logic sb,
                          input logic tb);
    drain();
    write_reg(REG_SRC_TYPE, s);
    write_reg(REG_TGT_TYPE, t);
    write_reg(REG_SRC_BE, {2'b0, sb});
    write_reg(REG_TGT_BE, {2'b0, tb});
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    // bias toward float specials and small integers
    case ($urandom_range(0, 9))
      0: v[62:52] = '1;
      1: v[62:52] = '0;
      2: v[30:23] = '1;
      3: v[30:23] = '0;
      4: v = 64'($signed($urandom_range(0, 40)) - 20);
      5: v[62:52] = 11'(11'd1023 + $urandom_range(0, 70));
      6: v[30:23] = 8'(8'd127 + $urandom_range(0, 40));
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed;
    logic [63:0] pats[13];
    pats = '{64'h0, 64'hffffffffffffffff, 64'h8000000000000000, 64'h7fffffffffffffff,
             64'h7ff0000000000000, 64'hfff0000000000000, 64'h7ff8000000000001,
             64'h000000007f800000, 64'h00000000ff800000, 64'h000000007fc00001,
             64'h0000000080000000, 64'h43e0000000000000, 64'h0000000000000001};
    for (int s = 0; s < 6; s++) begin
      set_mode(3'(s), 3'(5 - s), s[0], s[1]);
      foreach (pats[i]) if (i < 4 || s >= 4) send_word(pats[i], i == 12);
    end
    set_mode(3'd6, TY_F32, 1'b0, 1'b0);
    send_word(64'h1234, 1'b1);
    set_mode(TY_I32, 3'd7, 1'b1, 1'b1);
    send_word(64'h1234, 1'b0);
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0)
        set_mode(3'($urandom_range(0, 7) % 6 == 0 ? $urandom_range(0, 7)
                                                   : $urandom_range(0, 5)),
                 3'($urandom_range(0, 5)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      send_word(rand64(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_backpressure;
    set_mode(TY_F64, TY_I32, 1'b1, 1'b0);
    hold_cycles = 60;
    for (int k = 0; k < 20; k++) send_word(rand64(), k == 19);
    drain();
    for (int k = 0; k < 10; k++) send_word(rand64(), 1'b0);
  endtask

  initial begin
    src_ty = TY_I32; tgt_ty = TY_I32; src_be = 0; tgt_be = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(800);
    idle_on = 1'b0;
    test_random(100);
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
